// ===== src/otlm_pkg.sv =====
package otlm_pkg;

    localparam int WindowBytes = 10;
    localparam int SkipLimit   = 10;

    localparam logic [5:0] KindEof        = 6'd0;
    localparam logic [5:0] KindInvalid    = 6'd1;
    localparam logic [5:0] KindSingleBase = 6'd2;
    localparam logic [5:0] KindDoubleBase = 6'd27;
    localparam logic [5:0] KindTripleBase = 6'd48;

    localparam logic [7:0] CharSemicolon = 8'h3B;
    localparam logic [7:0] CharSpace     = 8'h20;
    localparam logic [7:0] CharTab       = 8'h09;
    localparam logic [7:0] CharCr        = 8'h0D;

    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
        logic [7:0] byte_8;
        logic [7:0] byte_9;
        logic [3:0] bytes_available;
    } in_beat_t;

    typedef struct packed {
        logic [5:0] token_kind;
        logic [3:0] consumed_length;
    } out_beat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
    endfunction

    // Returns KindInvalid when c starts no operator.
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [4:0] idx;
        logic       hit;
        hit = 1'b1;
        idx = 5'd0;
        case (c)
            "(": idx = 5'd0;
            ")": idx = 5'd1;
            "[": idx = 5'd2;
            "]": idx = 5'd3;
            "{": idx = 5'd4;
            "}": idx = 5'd5;
            ";": idx = 5'd6;
            ",": idx = 5'd7;
            "~": idx = 5'd8;
            "?": idx = 5'd9;
            "*": idx = 5'd10;
            "/": idx = 5'd11;
            "%": idx = 5'd12;
            "^": idx = 5'd13;
            "|": idx = 5'd14;
            "&": idx = 5'd15;
            "<": idx = 5'd16;
            ">": idx = 5'd17;
            "=": idx = 5'd18;
            "!": idx = 5'd19;
            "+": idx = 5'd20;
            "-": idx = 5'd21;
            ".": idx = 5'd22;
            ":": idx = 5'd23;
            "#": idx = 5'd24;
            default: hit = 1'b0;
        endcase
        return hit ? (KindSingleBase + 6'(idx)) : KindInvalid;
    endfunction

    function automatic logic [5:0] double_kind(input logic [7:0] c0, input logic [7:0] c1);
        logic [4:0] idx;
        logic       hit;
        hit = 1'b1;
        idx = 5'd0;
        case ({c0, c1})
            "++": idx = 5'd0;
            "+=": idx = 5'd1;
            "--": idx = 5'd2;
            "-=": idx = 5'd3;
            "->": idx = 5'd4;
            "*=": idx = 5'd5;
            "/=": idx = 5'd6;
            "%=": idx = 5'd7;
            "^=": idx = 5'd8;
            "&&": idx = 5'd9;
            "&=": idx = 5'd10;
            "||": idx = 5'd11;
            "|=": idx = 5'd12;
            "<<": idx = 5'd13;
            "<=": idx = 5'd14;
            ">>": idx = 5'd15;
            ">=": idx = 5'd16;
            "==": idx = 5'd17;
            "!=": idx = 5'd18;
            "::": idx = 5'd19;
            "##": idx = 5'd20;
            default: hit = 1'b0;
        endcase
        return hit ? (KindDoubleBase + 6'(idx)) : KindInvalid;
    endfunction

    function automatic logic [5:0] triple_kind(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2);
        logic [1:0] idx;
        logic       hit;
        hit = 1'b1;
        idx = 2'd0;
        case ({c0, c1, c2})
            "...": idx = 2'd0;
            "<<<": idx = 2'd1;
            ">>>": idx = 2'd2;
            "<=>": idx = 2'd3;
            default: hit = 1'b0;
        endcase
        return hit ? (KindTripleBase + 6'(idx)) : KindInvalid;
    endfunction

endpackage

// ===== src/otlm_if.sv =====
interface otlm_in_if;
    logic               valid;
    logic               ready;
    otlm_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface otlm_out_if;
    logic                valid;
    logic                ready;
    otlm_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/operator_token_longest_match.sv =====
// An accepted beat is captured in the input register; its result is offered from the result register.
// Throughput: one beat per cycle while the result side accepts; input register, match logic, result register.
// Backpressure on the result side stalls both stages; a new beat is taken
// whenever the input register is empty or moving on.
// Reset (rst_n low, asynchronous): both stages emptied, no result offered.
module operator_token_longest_match (
    input  logic            clk,
    input  logic            rst_n,
    otlm_in_if.sink         req,
    otlm_out_if.source      rsp
);

    logic                 s1_valid_reg;
    otlm_pkg::in_beat_t   s1_data_reg;
    logic                 s2_valid_reg;
    otlm_pkg::out_beat_t  s2_data_reg;
    otlm_pkg::out_beat_t  s2_data_next;

    logic                 s2_advance;
    logic                 s1_advance;

    logic [7:0]                       win [otlm_pkg::WindowBytes];
    logic [3:0]                       avail;
    logic [3:0]                       skip_limit;
    logic [otlm_pkg::WindowBytes-1:0] cont;
    logic [5:0]                       k3;
    logic [5:0]                       k2;
    logic [5:0]                       k1;
    logic [3:0]                       run_len;

    assign s2_advance = !s2_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && s2_advance;
    assign req.ready  = !s1_valid_reg || s2_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_advance)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_data_reg <= req.data;
        end
        if (s1_advance)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign win[0] = s1_data_reg.byte_0;
    assign win[1] = s1_data_reg.byte_1;
    assign win[2] = s1_data_reg.byte_2;
    assign win[3] = s1_data_reg.byte_3;
    assign win[4] = s1_data_reg.byte_4;
    assign win[5] = s1_data_reg.byte_5;
    assign win[6] = s1_data_reg.byte_6;
    assign win[7] = s1_data_reg.byte_7;
    assign win[8] = s1_data_reg.byte_8;
    assign win[9] = s1_data_reg.byte_9;

    assign avail = (s1_data_reg.bytes_available > 4'(otlm_pkg::WindowBytes))
                   ? 4'(otlm_pkg::WindowBytes) : s1_data_reg.bytes_available;
    assign skip_limit = (avail > 4'(otlm_pkg::SkipLimit)) ? 4'(otlm_pkg::SkipLimit) : avail;

    assign k3 = otlm_pkg::triple_kind(win[0], win[1], win[2]);
    assign k2 = otlm_pkg::double_kind(win[0], win[1]);
    assign k1 = otlm_pkg::single_kind(win[0]);

    // Junk run: stops at whitespace, semicolon, an operator start past the first byte, or the skip limit.
    always_comb
    begin
        for (int i = 0; i < otlm_pkg::WindowBytes; i++)
        begin
            cont[i] = (i < int'(skip_limit)) && !otlm_pkg::is_space(win[i])
                      && (win[i] != otlm_pkg::CharSemicolon)
                      && ((i == 0) || (otlm_pkg::single_kind(win[i]) == otlm_pkg::KindInvalid));
        end
        run_len = 4'(otlm_pkg::WindowBytes);
        for (int i = otlm_pkg::WindowBytes - 1; i >= 0; i--)
        begin
            if (!cont[i])
            begin
                run_len = 4'(i);
            end
        end
    end

    always_comb
    begin
        if (avail == 4'd0)
        begin
            s2_data_next.token_kind      = otlm_pkg::KindEof;
            s2_data_next.consumed_length = 4'd0;
        end
        else if ((avail >= 4'd3) && (k3 != otlm_pkg::KindInvalid))
        begin
            s2_data_next.token_kind      = k3;
            s2_data_next.consumed_length = 4'd3;
        end
        else if ((avail >= 4'd2) && (k2 != otlm_pkg::KindInvalid))
        begin
            s2_data_next.token_kind      = k2;
            s2_data_next.consumed_length = 4'd2;
        end
        else if (k1 != otlm_pkg::KindInvalid)
        begin
            s2_data_next.token_kind      = k1;
            s2_data_next.consumed_length = 4'd1;
        end
        else
        begin
            s2_data_next.token_kind      = otlm_pkg::KindInvalid;
            s2_data_next.consumed_length = run_len;
        end
    end

    assign rsp.valid = s2_valid_reg;
    assign rsp.data  = s2_data_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted beat did not reach input register");

    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.token_kind == otlm_pkg::KindEof))
        |-> (rsp.data.consumed_length == 4'd0))
        else $error("end of source with nonzero length");

    a_triple_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.data.token_kind >= otlm_pkg::KindTripleBase))
        |-> (rsp.data.consumed_length == 4'd3))
        else $error("three-byte operator with wrong length");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.consumed_length <= 4'(otlm_pkg::WindowBytes)))
        else $error("consumed length beyond window");

endmodule

// ===== tb/operator_token_longest_match_tb.sv =====
`timescale 1ns / 100ps

module operator_token_longest_match_tb;

    localparam int NumSingle   = 25;
    localparam int NumPair     = 21;
    localparam int NumTriple   = 4;
    localparam int NumDirected = 24;
    localparam int QuietLimit  = 2000;
    localparam int HoldCycles  = 60;
    localparam int HoldAfter   = 1000;
    localparam int WinBits     = 8 * otlm_pkg::WindowBytes;

    localparam logic [8*NumSingle-1:0] SingleOps = "()[]{};,~?*/%^|&<>=!+-.:#";
    localparam logic [16*NumPair-1:0] PairOps = {
        "++", "+=", "--", "-=", "->", "*=", "/=", "%=", "^=", "&&", "&=",
        "||", "|=", "<<", "<=", ">>", ">=", "==", "!=", "::", "##"
    };
    localparam logic [24*NumTriple-1:0] TripleOps = {"...", "<<<", ">>>", "<=>"};

    typedef struct packed {
        logic [WinBits-1:0] text;
        logic [3:0]         avail;
        logic               known;
        logic [5:0]         kind;
        logic [3:0]         len;
    } lex_case_t;

    logic clk = 1'b0;
    logic rst_n;

    otlm_in_if  req_if ();
    otlm_out_if rsp_if ();

    operator_token_longest_match u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    otlm_pkg::out_beat_t expected_tokens[$];
    lex_case_t           directed_cases [NumDirected];
    int                  error_count    = 0;
    int                  windows_sent   = 0;
    int                  send_gap_pct   = 28;
    int                  recv_stall_pct = 64;
    int                  quiet_cycles   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Position of c in the single-character table, -1 if it starts no operator.
    function automatic int single_slot(input logic [7:0] c);
        for (int i = 0; i < NumSingle; i++)
        begin
            if (SingleOps[8*(NumSingle-1-i) +: 8] == c)
                return i;
        end
        return -1;
    endfunction

    function automatic otlm_pkg::out_beat_t lex_token(input otlm_pkg::in_beat_t beat);
        logic [WinBits-1:0]  text;
        logic [7:0]          c;
        int                  avail;
        int                  stop;
        int                  n;
        otlm_pkg::out_beat_t tok;
        text  = beat[$bits(otlm_pkg::in_beat_t)-1 -: WinBits];
        avail = int'(beat.bytes_available);
        if (avail > otlm_pkg::WindowBytes)
            avail = otlm_pkg::WindowBytes;
        tok.token_kind      = otlm_pkg::KindInvalid;
        tok.consumed_length = '0;
        if (avail == 0)
        begin
            tok.token_kind = otlm_pkg::KindEof;
            return tok;
        end
        if (avail >= 3)
        begin
            for (int i = 0; i < NumTriple; i++)
            begin
                if (text[WinBits-1 -: 24] == TripleOps[24*(NumTriple-1-i) +: 24])
                begin
                    tok.token_kind      = otlm_pkg::KindTripleBase + 6'(i);
                    tok.consumed_length = 4'd3;
                    return tok;
                end
            end
        end
        if (avail >= 2)
        begin
            for (int i = 0; i < NumPair; i++)
            begin
                if (text[WinBits-1 -: 16] == PairOps[16*(NumPair-1-i) +: 16])
                begin
                    tok.token_kind      = otlm_pkg::KindDoubleBase + 6'(i);
                    tok.consumed_length = 4'd2;
                    return tok;
                end
            end
        end
        n = single_slot(text[WinBits-1 -: 8]);
        if (n >= 0)
        begin
            tok.token_kind      = otlm_pkg::KindSingleBase + 6'(n);
            tok.consumed_length = 4'd1;
            return tok;
        end
        // junk run: stops at whitespace, semicolon, a later operator start or the skip limit
        stop = (otlm_pkg::SkipLimit < otlm_pkg::WindowBytes)
               ? otlm_pkg::SkipLimit : otlm_pkg::WindowBytes;
        if (stop > avail)
            stop = avail;
        for (n = 0; n < stop; n++)
        begin
            c = text[8*(otlm_pkg::WindowBytes-1-n) +: 8];
            if (c == otlm_pkg::CharSpace || (c >= otlm_pkg::CharTab && c <= otlm_pkg::CharCr)
                || c == otlm_pkg::CharSemicolon)
                break;
            if (n > 0 && single_slot(c) >= 0)
                break;
        end
        tok.consumed_length = 4'(n);
        return tok;
    endfunction

    function automatic otlm_pkg::in_beat_t random_window();
        logic [WinBits-1:0] text;
        logic [3:0]         avail;
        int                 pick;
        int                 slot;
        for (int k = 0; k < otlm_pkg::WindowBytes; k++)
        begin
            pick = int'($urandom_range(99));
            if (pick < 55)
            begin
                slot = int'($urandom_range(NumSingle - 1));
                text[8*(otlm_pkg::WindowBytes-1-k) +: 8] = SingleOps[8*slot +: 8];
            end
            else if (pick < 62)
                text[8*(otlm_pkg::WindowBytes-1-k) +: 8] = 8'($urandom_range(13, 9));
            else if (pick < 67)
                text[8*(otlm_pkg::WindowBytes-1-k) +: 8] = otlm_pkg::CharSpace;
            else if (pick < 87)
                text[8*(otlm_pkg::WindowBytes-1-k) +: 8] = 8'(8'h61 + $urandom_range(25));
            else
                text[8*(otlm_pkg::WindowBytes-1-k) +: 8] = 8'($urandom_range(255));
        end
        pick = int'($urandom_range(99));
        if (pick < 20)
        begin
            slot = int'($urandom_range(NumTriple - 1));
            text[WinBits-1 -: 24] = TripleOps[24*slot +: 24];
        end
        else if (pick < 50)
        begin
            slot = int'($urandom_range(NumPair - 1));
            text[WinBits-1 -: 16] = PairOps[16*slot +: 16];
        end
        if ($urandom_range(99) < 60)
            avail = 4'd10;
        else
            avail = 4'($urandom_range(15));
        return {text, avail};
    endfunction

    task automatic send_window(input otlm_pkg::in_beat_t beat, input otlm_pkg::out_beat_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_tokens.push_back(want);
        windows_sent++;
    endtask

    task automatic send_random(input int count);
        otlm_pkg::in_beat_t beat;
        repeat (count)
        begin
            beat = random_window();
            send_window(beat, lex_token(beat));
        end
    endtask

    initial
    begin
        otlm_pkg::in_beat_t  beat;
        otlm_pkg::out_beat_t want;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        directed_cases = '{
            '{"<<<=aaaaaa", 4'd0,  1'b1, otlm_pkg::KindEof,               4'd0},
            '{"<<<=aaaaaa", 4'd10, 1'b1, otlm_pkg::KindTripleBase + 6'd1, 4'd3},
            '{"...x......", 4'd10, 1'b1, otlm_pkg::KindTripleBase,        4'd3},
            '{">>>>>>>>>>", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"<=>=======", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"<<<<<<<<<<", 4'd2,  1'b0, otlm_pkg::KindEof,               4'd0},
            '{"<=>aaaaaaa", 4'd1,  1'b0, otlm_pkg::KindEof,               4'd0},
            '{"..x.......", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"->->->->->", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"##::##::##", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"::::::::::", 4'd1,  1'b0, otlm_pkg::KindEof,               4'd0},
            '{";;;;;;;;;;", 4'd10, 1'b0, otlm_pkg::KindEof,               4'd0},
            '{"abcdefghij", 4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd10},
            '{"\377\200\377\200\377\200\377\200\377\200",
                            4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd10},
            '{80'h0,        4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd10},
            '{"\377\377\377\377\377\377\377\377\377\377",
                            4'd15, 1'b1, otlm_pkg::KindInvalid,           4'd10},
            '{" abcdefghi", 4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd0},
            '{"\rabcdefghi", 4'd10, 1'b1, otlm_pkg::KindInvalid,          4'd0},
            '{"abc;defghi", 4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd3},
            '{"ab+cdefghi", 4'd10, 1'b1, otlm_pkg::KindInvalid,           4'd2},
            '{"a\tbcdefghi", 4'd10, 1'b1, otlm_pkg::KindInvalid,          4'd1},
            '{"x\vyyyyyyyy", 4'd10, 1'b1, otlm_pkg::KindInvalid,          4'd1},
            '{"zzzzzzzzzz", 4'd4,  1'b1, otlm_pkg::KindInvalid,           4'd4},
            '{"zzzzzzzzzz", 4'd15, 1'b1, otlm_pkg::KindInvalid,           4'd10}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cases[i])
        begin
            beat = {directed_cases[i].text, directed_cases[i].avail};
            if (directed_cases[i].known)
                want = {directed_cases[i].kind, directed_cases[i].len};
            else
                want = lex_token(beat);
            send_window(beat, want);
        end
        send_random(430);

        send_gap_pct   = 64;
        recv_stall_pct = 28;
        send_random(430);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_random(440);
        req_if.valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back the pipe up
    initial
    begin
        logic held;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && windows_sent >= HoldAfter)
            begin
                held = 1'b1;
                repeat (HoldCycles)
                begin
                    rsp_if.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        otlm_pkg::out_beat_t want;
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected result beat, kind %0d length %0d", $time,
                         rsp_if.data.token_kind, rsp_if.data.consumed_length);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (rsp_if.data.token_kind !== want.token_kind)
                begin
                    $display("%0t: token_kind expected %0d actual %0d", $time,
                             want.token_kind, rsp_if.data.token_kind);
                    error_count++;
                end
                if (rsp_if.data.consumed_length !== want.consumed_length)
                begin
                    $display("%0t: consumed_length expected %0d actual %0d", $time,
                             want.consumed_length, rsp_if.data.consumed_length);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== files.f =====
src/otlm_pkg.sv
src/otlm_if.sv
src/operator_token_longest_match.sv
tb/operator_token_longest_match_tb.sv
